[rtl/bdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Operation and status codes, controller states and the command and status
// bundles shared by the deque controller and datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_POP_BACK   = 3'd1,
      KIND_PUSH_FRONT = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_DELETE     = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_NOMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic load_op;
      logic capture_match;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

[rtl/bdq_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one deque operation per beat.
// ----------------------------------------------------------------------------
interface bdq_req_if
   import bdq_pkg::*;
   ();

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);

endinterface

[rtl/bdq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque response channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface bdq_rsp_if
   import bdq_pkg::*;
   ();

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0]        element_count;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, read_value, element_count, status, input ready);
   modport sink   (input valid, read_value, element_count, status, output ready);

endinterface

[rtl/bdq_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Sequences each operation through accept, compare and commit.
// ----------------------------------------------------------------------------
module bdq_controller
   import bdq_pkg::*;
   (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
   );

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      cmd.load_op       = 1'b0;
      cmd.capture_match = 1'b0;
      cmd.commit        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_op = req_valid;
            if (req_valid) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.capture_match = 1'b1;
            state_in          = S_APPLY;
         end
         S_APPLY: begin
            // hold until the result register can take the beat
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/bdq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque datapath
// Row of data cells with parallel compare, shift in either direction,
// held count and the result register.
// ----------------------------------------------------------------------------
module bdq_datapath
   import bdq_pkg::*;
   #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
   )
   (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [COUNT_W-1:0]        rsp_element_count,
   output logic [STATUS_W-1:0]       rsp_status
   );

   localparam int CW = $clog2(DEPTH + 1);

   kind_type                  op_kind_ff;
   logic [DATA_WIDTH-1:0]     op_word_ff;
   logic [DATA_WIDTH-1:0]     cells_ff [DEPTH];
   logic [DATA_WIDTH-1:0]     cells_in [DEPTH];
   logic [DATA_WIDTH-1:0]     up_cell  [DEPTH];
   logic [DATA_WIDTH-1:0]     down_cell [DEPTH];
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic [DEPTH-1:0]          match_ff;
   logic [DEPTH-1:0]          match_in;
   logic [DEPTH-1:0]          after_match;
   logic [DEPTH-1:0]          back_sel;
   logic                      seen;
   logic                      full;
   logic                      empty;
   logic                      found;
   logic [DATA_WIDTH-1:0]     back_value;
   logic [DATA_WIDTH-1:0]     rv;
   status_type                st;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] read_value_ff;
   logic [COUNT_W-1:0]        element_count_ff;
   status_type                status_ff;

   // neighbor taps for the shift toward the front and toward the back
   for (genvar g = 0; g < DEPTH; g++) begin : g_taps
      if (g == DEPTH - 1) begin : g_last
         assign up_cell[g] = cells_ff[g];
      end else begin : g_mid
         assign up_cell[g] = cells_ff[g+1];
      end
      if (g == 0) begin : g_first
         assign down_cell[g] = op_word_ff;
      end else begin : g_rest
         assign down_cell[g] = cells_ff[g-1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         op_kind_ff <= kind_type'(req_kind);
         op_word_ff <= DATA_WIDTH'($unsigned(req_value));
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (CW'(i) < count_ff) && (cells_ff[i] == op_word_ff);
         back_sel[i] = (count_ff == CW'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_match) begin
         match_ff <= match_in;
      end
   end

   always_comb begin
      seen       = 1'b0;
      back_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         seen           = seen | match_ff[i];
         after_match[i] = seen;
         back_value     = back_value | (cells_ff[i] & {DATA_WIDTH{back_sel[i]}});
      end
   end

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign found = |match_ff;

   always_comb begin
      cells_in = cells_ff;
      count_in = count_ff;
      rv       = '0;
      st       = STATUS_OK;
      unique case (op_kind_ff)
         KIND_PUSH_BACK: begin
            if (full) begin
               st = STATUS_FULL;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (count_ff == CW'(i)) begin
                     cells_in[i] = op_word_ff;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         KIND_POP_BACK: begin
            if (empty) begin
               st = STATUS_EMPTY;
            end else begin
               rv       = back_value;
               count_in = count_ff - CW'(1);
            end
         end
         KIND_PUSH_FRONT: begin
            if (full) begin
               st = STATUS_FULL;
            end else begin
               cells_in = down_cell;
               count_in = count_ff + CW'(1);
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               st = STATUS_EMPTY;
            end else begin
               rv       = cells_ff[0];
               cells_in = up_cell;
               count_in = count_ff - CW'(1);
            end
         end
         KIND_DELETE: begin
            if (found) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (after_match[i]) begin
                     cells_in[i] = up_cell[i];
                  end
               end
               count_in = count_ff - CW'(1);
            end else begin
               st = STATUS_NOMATCH;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         cells_ff         <= cells_in;
         read_value_ff    <= VALUE_W'($signed(rv));
         element_count_ff <= COUNT_W'(count_in);
         status_ff        <= st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = read_value_ff;
   assign rsp_element_count = element_count_ff;
   assign rsp_status        = status_ff;

endmodule

[rtl/bounded_deque_with_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with delete
// Double-ended queue of DEPTH signed words with push and pop at both ends
// and delete of the first matching entry.
// ----------------------------------------------------------------------------
// Each request beat carries one operation and yields exactly one response
// beat with the popped word, the count after the operation and a status
// (ok, pop on empty, push on full dropped, delete found no match). An
// operation has three steps: accept, a compare of every held cell
// against the request word into a registered match row, then the shift of
// the cell row and the load of the response register. The next request is
// taken as soon as the previous one has committed, while its response may
// still wait on the response channel. No clearing pass follows reset; only
// held cells are ever read.
module bounded_deque_with_delete
   import bdq_pkg::*;
   #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
   )
   (
   input logic      clock,
   input logic      reset,
   bdq_req_if.sink   req_ch,
   bdq_rsp_if.source rsp_ch
   );

   cmd_type  cmd;
   stat_type stat;

   bdq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_ch.kind),
      .req_value         (req_ch.value),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_read_value    (rsp_ch.read_value),
      .rsp_element_count (rsp_ch.element_count),
      .rsp_status        (rsp_ch.status)
   );

endmodule

[rtl/bdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level checks on the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
   import bdq_pkg::*;
   #(
   parameter int DEPTH = 16
   )
   (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_read_value,
   input logic [COUNT_W-1:0]        rsp_element_count,
   input logic [STATUS_W-1:0]       rsp_status
   );

   localparam logic WIDE = (DEPTH > 31);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_element_count))
      else $error("stalled response beat changed");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (rsp_element_count == '0 && rsp_read_value == '0))
      else $error("pop on empty with nonzero count or data");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_read_value == '0 && (WIDE || rsp_element_count == COUNT_W'(DEPTH))))
      else $error("push on full reported while not full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (WIDE || rsp_element_count <= COUNT_W'(DEPTH)))
      else $error("element count above depth");

endmodule

bind bounded_deque_with_delete bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_read_value    (rsp_ch.read_value),
   .rsp_element_count (rsp_ch.element_count),
   .rsp_status        (rsp_ch.status)
);

[sim/bounded_deque_with_delete_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque with delete testbench
// Drives push, pop and delete operations with random gaps on the request
// side and random stalls on the response side. A shadow deque predicts the
// popped word, the count and the status of every operation, and each
// response beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete_test;
   import bdq_pkg::*;

   localparam int DEQUE_DEPTH = 16;
   localparam int RANDOM_OPS  = 1000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENT_OPS = 40;
   localparam int REPORT_MAX  = 10;

   localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN,
      MIX_DELETE
   } mix_type;

   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        element_count;
      logic [STATUS_W-1:0]       status;
   } deque_result_type;

   class deque_model_type;
      logic signed [VALUE_W-1:0] cells[$];
      deque_result_type          pending_results[$];
      int                        failures;

      function void apply_op(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] word);
         deque_result_type res;
         res.read_value = '0;
         res.status     = STATUS_OK;
         case (kind) inside
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
               if (cells.size() >= DEQUE_DEPTH)
                  res.status = STATUS_FULL;
               else if (kind == KIND_PUSH_BACK)
                  cells.push_back(word);
               else
                  cells.push_front(word);
            end
            KIND_POP_BACK: begin
               if (cells.size() == 0)
                  res.status = STATUS_EMPTY;
               else
                  res.read_value = cells.pop_back();
            end
            KIND_POP_FRONT: begin
               if (cells.size() == 0)
                  res.status = STATUS_EMPTY;
               else
                  res.read_value = cells.pop_front();
            end
            KIND_DELETE: begin
               res.status = STATUS_NOMATCH;
               foreach (cells[i]) begin
                  if (cells[i] == word) begin
                     cells.delete(i);
                     res.status = STATUS_OK;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
         res.element_count = COUNT_W'(cells.size());
         pending_results.push_back(res);
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] rv, logic [COUNT_W-1:0] cnt,
                                 logic [STATUS_W-1:0] st);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("unexpected response beat: read_value %0d count %0d status %0d",
                        rv, cnt, st);
            return;
         end
         want = pending_results.pop_front();
         if (rv !== want.read_value || cnt !== want.element_count || st !== want.status) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("response mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                        want.read_value, want.element_count, want.status, rv, cnt, st);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   bit   req_quiet;
   bit   rsp_quiet;
   int   rsp_hold;

   logic signed [VALUE_W-1:0] word_pool[8];
   deque_model_type           shadow_deque;

   bdq_req_if req_ch ();
   bdq_rsp_if rsp_ch ();

   bounded_deque_with_delete #(
      .DEPTH      (DEQUE_DEPTH),
      .DATA_WIDTH (VALUE_W)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return word_pool[$urandom_range(0, 7)];
      if (r < 8 && shadow_deque.cells.size() > 0)
         return shadow_deque.cells[$urandom_range(0, shadow_deque.cells.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(mix_type mix);
      int push_pct;
      int pop_pct;
      int r;
      case (mix)
         MIX_FILL:   begin push_pct = 70; pop_pct = 15; end
         MIX_DRAIN:  begin push_pct = 15; pop_pct = 70; end
         MIX_DELETE: begin push_pct = 45; pop_pct = 10; end
         default:    begin push_pct = 40; pop_pct = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 3)
         return KIND_W'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      if (r < push_pct + pop_pct)
         return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
      return KIND_DELETE;
   endfunction

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] word);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.value <= word;
      do @(posedge clock); while (!req_ch.ready);
      shadow_deque.apply_op(kind, word);
   endtask

   // response side: check every beat, stall at random
   initial begin
      rsp_ch.ready <= 1'b0;
      rsp_hold = 0;
      rsp_quiet = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            shadow_deque.check_result(rsp_ch.read_value, rsp_ch.element_count,
                                      rsp_ch.status);
         if ($urandom_range(0, 199) == 0)
            rsp_quiet = !rsp_quiet;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               rsp_hold = pick_gap(rsp_quiet);
         end
      end
   end

   initial begin
      mix_type mix;
      shadow_deque = new();
      cycle_count  = 0;
      req_quiet    = 1'b0;
      word_pool[0] = 32'sh0000_0000;
      word_pool[1] = -32'sd1;
      word_pool[2] = 32'sh8000_0000;
      word_pool[3] = 32'sh7fff_ffff;
      for (int i = 4; i < 8; i++)
         word_pool[i] = $urandom;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_PUSH_BACK;
      req_ch.value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue, spare codes, extremes at both ends
      send_op(KIND_POP_BACK, 32'sh7fff_ffff);
      send_op(KIND_POP_FRONT, -32'sd1);
      send_op(KIND_DELETE, 32'sh0000_0000);
      send_op(KIND_SPARE_5, 32'sh1234_5678);
      send_op(KIND_SPARE_6, -32'sd1);
      send_op(KIND_SPARE_7, 32'sh8000_0000);
      send_op(KIND_PUSH_BACK, 32'sh8000_0000);
      send_op(KIND_PUSH_FRONT, 32'sh7fff_ffff);
      send_op(KIND_PUSH_BACK, -32'sd1);
      send_op(KIND_PUSH_FRONT, 32'sh0000_0000);
      send_op(KIND_PUSH_BACK, -32'sd1);
      send_op(KIND_DELETE, -32'sd1);
      send_op(KIND_DELETE, 32'sh0001_2345);
      send_op(KIND_SPARE_5, 32'sh0000_0000);
      send_op(KIND_POP_FRONT, 32'sh0000_0000);
      send_op(KIND_POP_BACK, 32'sh0000_0000);
      send_op(KIND_DELETE, 32'sh8000_0000);
      send_op(KIND_POP_BACK, 32'sh0000_0000);
      send_op(KIND_POP_FRONT, 32'sh0000_0000);

      mix = MIX_FILL;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % SEGMENT_OPS == 0) begin
            mix = mix_type'($urandom_range(MIX_FILL, MIX_DELETE));
            req_quiet = ($urandom_range(0, 3) == 0);
         end
         send_op(pick_kind(mix), pick_word());
      end
      req_ch.valid <= 1'b0;

      while (shadow_deque.pending_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (shadow_deque.failures == 0 && shadow_deque.pending_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/bdq_pkg.sv
rtl/bdq_req_if.sv
rtl/bdq_rsp_if.sv
rtl/bdq_controller.sv
rtl/bdq_datapath.sv
rtl/bounded_deque_with_delete.sv
rtl/bdq_checker.sv
sim/bounded_deque_with_delete_test.sv
